>>> src/prt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants
// Slot layout, opcodes and result codes of the probe retry scheduler table.
// ----------------------------------------------------------------------------
package prt_pkg;

  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpRemove = 2'd1,
    OpTick   = 2'd2
  } op_e;

  localparam logic KindSend   = 1'b0;
  localparam logic KindReject = 1'b1;

  // register index of probe_count on the configuration port
  localparam logic RegProbeCount = 1'b0;

  localparam logic [7:0]  ProbeReset = 8'd40;
  localparam logic [10:0] DelayMax   = 11'd2047;
  localparam int          MaxResults = 16;
  localparam int          NresW      = $clog2(MaxResults + 1);

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] probe_port;
    logic [15:0] msg_kind;
    logic [3:0]  link;
    logic [10:0] delay;
    logic [7:0]  probes;
  } slot_t;

  typedef struct packed {
    logic  valid;
    slot_t slot;
  } entry_t;

  // what the head of the ring reports for the entry passing it
  typedef struct packed {
    logic   emit;
    logic   key_hit;
    logic   free;
    entry_t next;
  } head_res_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] msg_kind;
    logic [3:0]  link;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

>>> src/prt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cell: one table slot of the ring
// Holds one peer entry; takes its neighbor's entry on a shift or a direct load.
// ----------------------------------------------------------------------------
module prt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire prt_pkg::entry_t shift_data_i,
  input  wire logic            load_i,
  input  wire prt_pkg::entry_t load_data_i,
  output prt_pkg::entry_t      entry_o
);

  logic           valid_q;
  prt_pkg::slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= load_data_i.valid;
    end else if (shift_i) begin
      valid_q <= shift_data_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= load_data_i.slot;
    end else if (shift_i) begin
      slot_q <= shift_data_i.slot;
    end
  end

  assign entry_o.valid = valid_q;
  assign entry_o.slot  = slot_q;

endmodule
`default_nettype wire

>>> src/prt_head.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_head: entry update at the head of the ring
// Key match, removal, free-slot detect, delay countdown and probe emission for one slot.
// ----------------------------------------------------------------------------
module prt_head (
  input  wire prt_pkg::op_e    op_i,
  input  wire prt_pkg::entry_t entry_i,
  input  wire logic [31:0]     key_addr_i,
  input  wire logic [15:0]     key_port_i,
  input  wire logic            can_send_i,
  output prt_pkg::head_res_t   res_o
);

  logic key_hit;

  assign key_hit = entry_i.valid && (entry_i.slot.addr == key_addr_i) &&
                   (entry_i.slot.port == key_port_i);

  always_comb begin
    res_o         = '0;
    res_o.next    = entry_i;
    res_o.key_hit = key_hit;
    res_o.free    = !entry_i.valid;
    case (op_i)
      prt_pkg::OpRemove: begin
        if (key_hit) begin
          res_o.next.valid = 1'b0;
        end
      end
      prt_pkg::OpTick: begin
        if (entry_i.valid) begin
          if (entry_i.slot.delay != 11'd0) begin
            res_o.next.slot.delay = entry_i.slot.delay - 11'd1;
          end else if (entry_i.slot.probes != 8'd0) begin
            // over the per-tick cap the peer waits untouched
            if (can_send_i) begin
              res_o.emit             = 1'b1;
              res_o.next.slot.probes = entry_i.slot.probes - 8'd1;
              if (entry_i.slot.probes == 8'd1) begin
                res_o.next.valid = 1'b0;
              end
            end
          end else begin
            res_o.next.valid = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/probe_retry_scheduler_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// probe_retry_scheduler_table: peer table with timed handshake probes
// Add, remove and tick items walk a ring of slot cells past one update head.
// ----------------------------------------------------------------------------
// an item runs accept, one ring step per slot, then one closing step; a ring
//   step or closing step whose result finds the result stage full stalls until tready
// one item is in work at a time; a new item is taken only once the last is done
// a tick result is held until the next sender reaches the head or the closing step
// reset: async low; slots empty, probe_count 40, no clearing pass
module probe_retry_scheduler_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int TICK_MS       = 50
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // input items
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [31:0] peer_addr, [47:32] peer_port, [63:48] probe_port,
  // [79:64] msg_kind, [83:80] link_id, [99:84] start_delay, [103:100] zero
  input  wire logic [103:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [1:0]    s_axis_tuser_i,
  // result items
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // [31:0] out_addr, [47:32] out_port, [63:48] out_msg_kind,
  // [67:64] out_link, [71:68] zero
  output logic [71:0]        m_axis_tdata_o,
  // [0] result_kind
  output logic               m_axis_tuser_o,
  output logic               m_axis_tlast_o,
  // configuration
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  // ceil(2^32 / TICK_MS): exact quotient for every 16-bit delay
  localparam logic [32:0] Recip =
    33'(((64'd1 << 32) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWalk  = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [1:0]                  op_q;
  logic                        match_found_q, match_found_d;
  logic [IdxW-1:0]             match_idx_q, match_idx_d;
  logic                        free_found_q, free_found_d;
  logic [IdxW-1:0]             free_idx_q, free_idx_d;
  logic [prt_pkg::NresW-1:0]   nres_q, nres_d;
  logic                        hold_valid_q, hold_valid_d;
  prt_pkg::result_t            hold_q;
  logic                        out_valid_q, out_valid_d;
  prt_pkg::result_t            out_q, out_new;
  logic                        out_load;
  logic [7:0]                  probe_count_q;

  logic [31:0]                 key_addr_q;
  logic [15:0]                 key_port_q;
  logic [15:0]                 probe_port_q;
  logic [15:0]                 msg_kind_q;
  logic [3:0]                  link_q;
  logic [10:0]                 ticks_q;

  logic                        in_acc;
  logic                        out_free;
  logic                        walk_adv;
  logic                        cfg_wr;
  logic [48:0]                 dms_prod;
  logic [16:0]                 ticks_raw;
  logic [10:0]                 ticks_sat;
  logic                        load_en;
  logic [IdxW-1:0]             load_idx;
  prt_pkg::entry_t             load_entry;
  prt_pkg::result_t            send_res;
  prt_pkg::head_res_t          head_res;
  prt_pkg::entry_t             cell_q [TABLE_ENTRIES];

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // delay in ticks by reciprocal multiply, then saturate
  assign dms_prod  = 49'(s_axis_tdata_i[99:84]) * 49'(Recip);
  assign ticks_raw = dms_prod[48:32];
  assign ticks_sat = (ticks_raw > 17'(prt_pkg::DelayMax)) ? prt_pkg::DelayMax
                                                           : ticks_raw[10:0];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == prt_pkg::RegProbeCount);
  assign prdata = (paddr[2] == prt_pkg::RegProbeCount) ? {24'd0, probe_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_count_q <= prt_pkg::ProbeReset;
    end else if (cfg_wr) begin
      probe_count_q <= pwdata[7:0];
    end
  end

  // head of the ring sees slot idx_q during the walk
  prt_head u_head (
    .op_i       (prt_pkg::op_e'(op_q)),
    .entry_i    (cell_q[0]),
    .key_addr_i (key_addr_q),
    .key_port_i (key_port_q),
    .can_send_i (nres_q < prt_pkg::NresW'(prt_pkg::MaxResults)),
    .res_o      (head_res)
  );

  assign walk_adv = (state_q == StWalk) &&
                    !(head_res.emit && hold_valid_q && !out_free);

  assign load_idx = match_found_q ? match_idx_q : free_idx_q;
  assign load_en  = (state_q == StFlush) && (op_q == prt_pkg::OpAdd) &&
                    (match_found_q || free_found_q);

  assign load_entry.valid           = 1'b1;
  assign load_entry.slot.addr       = key_addr_q;
  assign load_entry.slot.port       = key_port_q;
  assign load_entry.slot.probe_port = probe_port_q;
  assign load_entry.slot.msg_kind   = msg_kind_q;
  assign load_entry.slot.link       = link_q;
  assign load_entry.slot.delay      = ticks_q;
  assign load_entry.slot.probes     = probe_count_q;

  assign send_res.kind     = prt_pkg::KindSend;
  assign send_res.addr     = cell_q[0].slot.addr;
  assign send_res.port     = cell_q[0].slot.probe_port;
  assign send_res.msg_kind = cell_q[0].slot.msg_kind;
  assign send_res.link     = cell_q[0].slot.link;
  assign send_res.last     = 1'b0;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    prt_pkg::entry_t shift_in;
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign shift_in = head_res.next;
    end else begin : g_mid
      assign shift_in = cell_q[k+1];
    end
    prt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .shift_i      (walk_adv),
      .shift_data_i (shift_in),
      .load_i       (load_en && (load_idx == IdxW'(k))),
      .load_data_i  (load_entry),
      .entry_o      (cell_q[k])
    );
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    nres_d        = nres_q;
    hold_valid_d  = hold_valid_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_load      = 1'b0;
    out_new       = hold_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d       = StWalk;
          idx_d         = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          nres_d        = '0;
          hold_valid_d  = 1'b0;
        end
      end
      StWalk: begin
        if (walk_adv) begin
          idx_d = idx_q + 1'b1;
          if (op_q == prt_pkg::OpAdd) begin
            if (head_res.key_hit && !match_found_q) begin
              match_found_d = 1'b1;
              match_idx_d   = idx_q;
            end
            if (head_res.free && !free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = idx_q;
            end
          end
          // one result is held back so the final one can carry last
          if (head_res.emit) begin
            nres_d       = nres_q + 1'b1;
            hold_valid_d = 1'b1;
            if (hold_valid_q) begin
              out_load = 1'b1;
            end
          end
          if (idx_q == LastIdx) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        case (op_q)
          prt_pkg::OpAdd: begin
            if (match_found_q || free_found_q) begin
              state_d = StIdle;
            end else if (out_free) begin
              out_load          = 1'b1;
              out_new.kind      = prt_pkg::KindReject;
              out_new.addr      = key_addr_q;
              out_new.port      = key_port_q;
              out_new.msg_kind  = msg_kind_q;
              out_new.link      = link_q;
              out_new.last      = 1'b1;
              state_d           = StIdle;
            end
          end
          prt_pkg::OpTick: begin
            if (!hold_valid_q) begin
              state_d = StIdle;
            end else if (out_free) begin
              out_load     = 1'b1;
              out_new.last = 1'b1;
              hold_valid_d = 1'b0;
              state_d      = StIdle;
            end
          end
          default: begin
            state_d = StIdle;
          end
        endcase
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      idx_q         <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      nres_q        <= '0;
      hold_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      nres_q        <= nres_d;
      hold_valid_q  <= hold_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    if (in_acc) begin
      op_q         <= s_axis_tuser_i;
      key_addr_q   <= s_axis_tdata_i[31:0];
      key_port_q   <= s_axis_tdata_i[47:32];
      probe_port_q <= s_axis_tdata_i[63:48];
      msg_kind_q   <= s_axis_tdata_i[79:64];
      link_q       <= s_axis_tdata_i[83:80];
      ticks_q      <= ticks_sat;
    end
    if (walk_adv && head_res.emit) begin
      hold_q <= send_res;
    end
    if (out_load) begin
      out_q <= out_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_q.link, out_q.msg_kind, out_q.port, out_q.addr};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.last;

endmodule
`default_nettype wire

>>> src/prt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prt_chk: port checker
// Watches the stream ports of the scheduler table over time.
// ----------------------------------------------------------------------------
module prt_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [71:0]  m_axis_tdata_o,
  input wire logic         m_axis_tuser_o,
  input wire logic         m_axis_tlast_o
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  // a rejected add is the only result of its item
  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("reject result without last");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

endmodule

bind probe_retry_scheduler_table prt_chk u_prt_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

>>> bench/probe_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_sched_checker: scoreboard for the probe retry scheduler table
// Watches the input, result and register channels, keeps its own copy of the
// peer table, predicts the handshake requests and rejections each item
// causes and compares every result field by field, in order.
// ----------------------------------------------------------------------------
module probe_sched_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [103:0]      s_axis_tdata_i,
  input  logic [1:0]        s_axis_tuser_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [71:0]       m_axis_tdata_i,
  input  logic              m_axis_tuser_i,
  input  logic              m_axis_tlast_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic [31:0]       prdata_i,
  input  logic              pready_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);

  localparam int         TABLE_ENTRIES  = 16;
  localparam int         TICK_MS        = 50;
  localparam logic [2:0] ProbeCountAddr = {prt_pkg::RegProbeCount, 2'b00};

  prt_pkg::entry_t  peer_tbl [TABLE_ENTRIES];
  logic [7:0]       probe_cnt;
  prt_pkg::result_t due_result_q[$];
  prt_pkg::result_t want;
  int unsigned      fails;

  function automatic int find_peer(logic [31:0] addr, logic [15:0] port);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (peer_tbl[i].valid && peer_tbl[i].slot.addr == addr && peer_tbl[i].slot.port == port)
        return i;
    end
    return -1;
  endfunction

  function automatic int field_err(string name, logic [31:0] exp_val, logic [31:0] got);
    if (got !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, got);
      return 1;
    end
    return 0;
  endfunction

  // applies one item to the table copy and queues the results it causes
  task automatic table_step(input logic [1:0] op, input logic [103:0] d);
    logic [31:0]      addr;
    logic [15:0]      port;
    logic [15:0]      pport;
    logic [15:0]      mkind;
    logic [3:0]       link;
    logic [15:0]      dms;
    logic [31:0]      ticks;
    int               s;
    int               n;
    prt_pkg::result_t r;
    addr  = d[31:0];
    port  = d[47:32];
    pport = d[63:48];
    mkind = d[79:64];
    link  = d[83:80];
    dms   = d[99:84];
    n     = 0;
    case (op)
      prt_pkg::OpAdd: begin
        ticks = dms / TICK_MS;
        if (ticks > prt_pkg::DelayMax) ticks = prt_pkg::DelayMax;
        s = find_peer(addr, port);
        // new key takes the lowest free slot
        for (int i = 0; i < TABLE_ENTRIES && s < 0; i++) begin
          if (!peer_tbl[i].valid) s = i;
        end
        if (s < 0) begin
          r = '{kind: prt_pkg::KindReject, addr: addr, port: port, msg_kind: mkind,
                link: link, last: 1'b1};
          due_result_q.push_back(r);
        end else begin
          peer_tbl[s].valid = 1'b1;
          peer_tbl[s].slot  = '{addr: addr, port: port, probe_port: pport, msg_kind: mkind,
                                link: link, delay: ticks[10:0], probes: probe_cnt};
        end
      end
      prt_pkg::OpRemove: begin
        s = find_peer(addr, port);
        if (s >= 0) peer_tbl[s].valid = 1'b0;
      end
      prt_pkg::OpTick: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (peer_tbl[i].valid) begin
            if (peer_tbl[i].slot.delay != 0) begin
              peer_tbl[i].slot.delay = peer_tbl[i].slot.delay - 11'd1;
            end else begin
              if (peer_tbl[i].slot.probes != 0 && n < prt_pkg::MaxResults) begin
                r = '{kind: prt_pkg::KindSend, addr: peer_tbl[i].slot.addr,
                      port: peer_tbl[i].slot.probe_port,
                      msg_kind: peer_tbl[i].slot.msg_kind, link: peer_tbl[i].slot.link,
                      last: 1'b0};
                due_result_q.push_back(r);
                n++;
                peer_tbl[i].slot.probes = peer_tbl[i].slot.probes - 8'd1;
              end
              if (peer_tbl[i].slot.probes == 0) peer_tbl[i].valid = 1'b0;
            end
          end
        end
        if (n > 0) begin
          r      = due_result_q.pop_back();
          r.last = 1'b1;
          due_result_q.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) peer_tbl[i] = '0;
      probe_cnt = prt_pkg::ProbeReset;
      due_result_q.delete();
      fails = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      // a result always belongs to an item accepted earlier
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0h addr %0h port %0h",
                   $time, m_axis_tuser_i, m_axis_tdata_i[31:0], m_axis_tdata_i[47:32]);
          fails++;
        end else begin
          want = due_result_q.pop_front();
          fails += field_err("result_kind", want.kind, m_axis_tuser_i);
          fails += field_err("out_addr", want.addr, m_axis_tdata_i[31:0]);
          fails += field_err("out_port", want.port, m_axis_tdata_i[47:32]);
          fails += field_err("out_msg_kind", want.msg_kind, m_axis_tdata_i[63:48]);
          fails += field_err("out_link", want.link, m_axis_tdata_i[67:64]);
          fails += field_err("last", want.last, m_axis_tlast_i);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) table_step(s_axis_tuser_i, s_axis_tdata_i);
      if (psel_i && penable_i && pready_i && paddr_i == ProbeCountAddr) begin
        if (pwrite_i) probe_cnt = pwdata_i[7:0];
        else fails += field_err("probe_count readback", {24'd0, probe_cnt}, prdata_i);
      end
      fail_cnt_o <= fails;
      pending_o  <= due_result_q.size();
    end
  end

endmodule

>>> bench/tb_probe_retry_scheduler_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_probe_retry_scheduler_table: testbench top for the probe scheduler table
// Drives directed and random add, remove and tick items with random gaps and
// result backpressure over several probe count settings; the checker beside
// the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_probe_retry_scheduler_table;

  localparam int         CLK_PERIOD     = 10;
  localparam int         TABLE_ENTRIES  = 16;
  localparam int         TICK_MS        = 50;
  localparam logic [1:0] OpIgnored      = 2'd3;
  localparam logic [2:0] ProbeCountAddr = {prt_pkg::RegProbeCount, 2'b00};
  localparam int         KEY_POOL       = 24;
  localparam int         PHASE_ITEMS    = 54;
  localparam int         HOLD_CYCLES    = 300;
  // an item with no result may still be walking the table
  localparam int         IDLE_CYCLES    = TABLE_ENTRIES + 24;
  // longest quiet stretch in a correct run is the long result hold
  localparam int         WDOG_LIMIT     = 3000;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata  = '0;
  logic [1:0]    s_axis_tuser  = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [71:0]   m_axis_tdata;
  logic          m_axis_tuser;
  logic          m_axis_tlast;
  logic          psel          = 1'b0;
  logic          penable       = 1'b0;
  logic          pwrite        = 1'b0;
  logic [2:0]    paddr         = '0;
  logic [31:0]   pwdata        = '0;
  logic [31:0]   prdata;
  logic          pready;

  int unsigned   fail_cnt;
  int unsigned   exp_pending;
  int unsigned   tx_gap_max    = 4;
  int unsigned   rx_gap_max    = 4;
  bit            hold_go       = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  probe_retry_scheduler_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .TICK_MS      (TICK_MS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  probe_sched_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .m_axis_tlast_i (m_axis_tlast),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (exp_pending)
  );

  function automatic logic [103:0] pack_item(logic [31:0] addr, logic [15:0] port,
                                             logic [15:0] pport, logic [15:0] mkind,
                                             logic [3:0] link, logic [15:0] dms);
    return {4'd0, dms, link, mkind, pport, port, addr};
  endfunction

  // small key pool so removes and replacing adds hit live peers
  function automatic logic [47:0] peer_key(int unsigned k);
    return {16'd7000 + 16'(k & 1), 32'h0A00_0000 + 32'(k >> 1)};
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [103:0] data);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
  endtask

  task automatic send_rand_item(output bit counted);
    int unsigned pick;
    logic [1:0]  op;
    logic [47:0] key;
    logic [15:0] dms;
    pick = $urandom_range(0, 99);
    if (pick < 34) op = prt_pkg::OpAdd;
    else if (pick < 50) op = prt_pkg::OpRemove;
    else if (pick < 96) op = prt_pkg::OpTick;
    else op = OpIgnored;
    if ($urandom_range(0, 99) < 85) key = peer_key($urandom_range(0, KEY_POOL - 1));
    else key = {16'($urandom()), $urandom()};
    // mostly short delays so peers start probing soon
    if ($urandom_range(0, 9) == 0) dms = 16'($urandom());
    else dms = 16'($urandom_range(0, 300));
    send_item(op, pack_item(key[31:0], key[47:32], 16'($urandom()), 16'($urandom()),
                            4'($urandom()), dms));
    counted = (op != OpIgnored);
  endtask

  // stop offering, then wait for every due result and the table walk to end
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (exp_pending != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ProbeCountAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_probe_count(input logic [7:0] value);
    wait_idle();
    reg_access(1'b1, {24'd0, value});
    reg_access(1'b0, '0);
  endtask

  // result side: random stalls per item, one long hold on request
  initial begin : rx_proc
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk_i);
    end
  end

  initial begin : wdog_proc
    int unsigned quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("probe_retry_scheduler_table verification failed");
    $finish;
  end

  initial begin : stim_proc
    logic [47:0] key;
    logic [7:0]  probes;
    int unsigned n;
    bit          counted;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_item(prt_pkg::OpTick, '0);
    send_item(OpIgnored, '1);
    send_item(prt_pkg::OpAdd, pack_item('1, '1, '1, '1, '1, 16'd0));
    send_item(prt_pkg::OpAdd, pack_item('0, '0, '0, '0, '0, 16'd100));
    // same key again: overwritten in place
    send_item(prt_pkg::OpAdd, pack_item('1, '1, 16'h1234, 16'hBEEF, 4'h5, 16'd0));
    send_item(prt_pkg::OpTick, '0);
    send_item(prt_pkg::OpRemove, pack_item(32'h1, 16'h1, '0, '0, '0, '0));
    send_item(prt_pkg::OpTick, '0);
    send_item(prt_pkg::OpTick, '0);
    send_item(prt_pkg::OpRemove, pack_item('1, '1, '0, '0, '0, '0));
    send_item(prt_pkg::OpTick, '0);
    // peer loaded with a zero count is dropped silently
    set_probe_count(8'd0);
    send_item(prt_pkg::OpAdd,
              pack_item(32'hC0A8_0001, 16'd443, 16'd9000, 16'd7, 4'd2, 16'd49));
    send_item(prt_pkg::OpTick, '0);
    set_probe_count(prt_pkg::ProbeReset);
    // fill the table, then one add too many
    for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
      key = peer_key(k);
      send_item(prt_pkg::OpAdd, pack_item(key[31:0], key[47:32], 16'($urandom()),
                                          16'($urandom()), 4'(k), 16'(k * 3)));
    end
    key = peer_key(TABLE_ENTRIES - 1);
    send_item(prt_pkg::OpAdd,
              pack_item(key[31:0], key[47:32], 16'hAAAA, 16'h5555, 4'hA, 16'd0));
    send_item(prt_pkg::OpTick, '0);

    // random phases over several probe counts
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       probes = 8'd1;
        1:       probes = 8'd255;
        2:       probes = 8'd2;
        3:       probes = 8'($urandom_range(1, 255));
        default: probes = prt_pkg::ProbeReset;
      endcase
      set_probe_count(probes);
      tx_gap_max = (p == 0) ? 0 : 4;
      rx_gap_max = (p == 0) ? 0 : 4;
      if (p == 1) hold_go = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        send_rand_item(counted);
        if (counted) n++;
      end
    end

    wait_idle();
    if (fail_cnt == 0 && exp_pending == 0) begin
      $display("probe_retry_scheduler_table verification clean");
    end else begin
      $display("probe_retry_scheduler_table verification failed");
    end
    $finish;
  end

endmodule
